[hdl/evs_pkg.sv]
// Shared types and constants of the energy voice activity segmenter.
// Used by every module of the block; depends on nothing.
package evs_pkg;

    localparam int MAX_FRAME_SAMPLES = 65536;

    localparam int PCM_W    = 16;
    localparam int SQ_W     = 2 * PCM_W - 1;
    localparam int CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
    // A frame holds at most MAX_FRAME_SAMPLES squares, so the sum never wraps.
    localparam int SUM_W    = SQ_W + $clog2(MAX_FRAME_SAMPLES);
    localparam int THR_W    = 31;
    localparam int HANG_W   = 8;
    localparam int SEG_W    = 32;
    localparam int PROD_W   = THR_W + CNT_W;
    localparam int QUIET_W  = 9;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;

    localparam logic [QUIET_W-1:0] QUIET_MAX = '1;
    localparam logic [SEG_W-1:0]   SEG_MAX   = '1;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(429497);
    localparam logic [HANG_W-1:0] HANG_RESET = HANG_W'(10);
    localparam logic [SEG_W-1:0]  MIN_RESET  = SEG_W'(16000);

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HANGOVER  = 2'd1,
        REG_MIN_SEG   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [HANG_W-1:0] hangover;
        logic [SEG_W-1:0]  min_segment;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } frame_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] limit;
        logic [CNT_W-1:0]  cnt;
    } judge_t;

endpackage

[hdl/evs_cfg.sv]
// APB register file: mean-square threshold, hangover and minimum segment length.
// Depends on evs_pkg.
module evs_cfg
    import evs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold   <= THR_RESET;
            cfg_reg.hangover    <= HANG_RESET;
            cfg_reg.min_segment <= MIN_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_THRESHOLD: cfg_reg.threshold   <= pwdata[THR_W-1:0];
                REG_HANGOVER:  cfg_reg.hangover    <= pwdata[HANG_W-1:0];
                REG_MIN_SEG:   cfg_reg.min_segment <= pwdata[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_THRESHOLD: prdata = APB_W'(cfg_reg.threshold);
            REG_HANGOVER:  prdata = APB_W'(cfg_reg.hangover);
            REG_MIN_SEG:   prdata = APB_W'(cfg_reg.min_segment);
            default:       prdata = '0;
        endcase
    end

endmodule

[hdl/evs_accum.sv]
// Sample stage and frame accumulator: squares each sample, sums squares and
// counts samples, and hands a finished frame on. Depends on evs_pkg.
module evs_accum
    import evs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [PCM_W-1:0] in_sample,
    input  logic                    in_last,
    output logic                    frame_valid,
    input  logic                    frame_ready,
    output frame_t                  frame
);

    logic              smp_valid_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              last_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              frm_valid_reg;
    frame_t            frame_reg;

    logic signed [2*PCM_W-1:0] sq_full;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              frame_end;
    logic              slot_free;
    logic              advance;

    assign sq_full = in_sample * in_sample;

    always_comb begin
        sum_next  = sum_reg + SUM_W'(sq_reg);
        cnt_next  = cnt_reg + 1'b1;
        // An overlong frame closes itself at the sample limit.
        frame_end = last_reg || (cnt_next == CNT_W'(MAX_FRAME_SAMPLES));
        slot_free = !frm_valid_reg || frame_ready;
        advance   = smp_valid_reg && (!frame_end || slot_free);
        in_ready  = !smp_valid_reg || advance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_valid_reg <= 1'b0;
            frm_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            if (in_ready) begin
                smp_valid_reg <= in_valid;
            end
            if (advance && frame_end) begin
                sum_reg       <= '0;
                cnt_reg       <= '0;
                frm_valid_reg <= 1'b1;
            end else begin
                if (advance) begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
                if (frame_ready) begin
                    frm_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sq_reg   <= sq_full[SQ_W-1:0];
            last_reg <= in_last;
        end
        if (advance && frame_end) begin
            frame_reg.sum <= sum_next;
            frame_reg.cnt <= cnt_next;
        end
    end

    assign frame_valid = frm_valid_reg;
    assign frame       = frame_reg;

endmodule

[hdl/evs_thresh.sv]
// Threshold stage: scales the mean-square threshold by the frame's sample
// count so that the mean never has to be divided out. Depends on evs_pkg.
module evs_thresh
    import evs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  frame_t           in_frame,
    input  logic [THR_W-1:0] threshold,
    output logic             out_valid,
    input  logic             out_ready,
    output judge_t           out_judge
);

    logic   valid_reg;
    judge_t judge_reg;
    judge_t judge_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        judge_next.sum   = in_frame.sum;
        judge_next.cnt   = in_frame.cnt;
        judge_next.limit = PROD_W'(threshold) * PROD_W'(in_frame.cnt);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            judge_reg <= judge_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_judge = judge_reg;

endmodule

[hdl/evs_decide.sv]
// Decision stage: voicing with hangover, segment length tracking and the
// result register that drives the master channel. Depends on evs_pkg.
module evs_decide
    import evs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  judge_t              in_judge,
    input  cfg_t                cfg,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic               out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [QUIET_W-1:0] quiet_reg;
    logic               voiced_reg;
    logic               inseg_reg;
    logic [SEG_W-1:0]   seg_reg;

    logic [QUIET_W-1:0] quiet_next;
    logic               voiced_next;
    logic               inseg_next;
    logic [SEG_W-1:0]   seg_next;
    logic [M_DATA_W-1:0] out_data_next;

    logic               advance;
    logic               loud;
    logic [QUIET_W-1:0] quiet_inc;
    logic [SEG_W:0]     seg_sum;
    logic [SEG_W-1:0]   seg_add;
    logic [SEG_W-1:0]   length;
    logic               done;
    logic               dropped;

    assign in_ready = !out_valid_reg || m_tready;
    assign advance  = in_valid && in_ready;

    always_comb begin
        loud      = {1'b0, in_judge.sum} > PROD_W'(in_judge.limit);
        quiet_inc = (quiet_reg == QUIET_MAX) ? quiet_reg : quiet_reg + 1'b1;
        seg_sum   = {1'b0, seg_reg} + (SEG_W + 1)'(in_judge.cnt);
        seg_add   = seg_sum[SEG_W] ? SEG_MAX : seg_sum[SEG_W-1:0];

        if (loud) begin
            quiet_next  = '0;
            voiced_next = 1'b1;
        end else begin
            quiet_next  = quiet_inc;
            voiced_next = (quiet_inc > QUIET_W'(cfg.hangover)) ? 1'b0 : voiced_reg;
        end

        inseg_next = inseg_reg;
        seg_next   = seg_reg;
        done       = 1'b0;
        dropped    = 1'b0;
        length     = '0;
        if (voiced_next) begin
            seg_next   = seg_add;
            inseg_next = 1'b1;
            length     = seg_add;
        end else if (inseg_reg) begin
            // Voicing just ended: qualify the segment and clear the detector.
            length     = seg_reg;
            done       = seg_reg >= cfg.min_segment;
            dropped    = !done;
            seg_next   = '0;
            inseg_next = 1'b0;
            quiet_next = '0;
        end

        out_data_next = {(M_DATA_W - SEG_W - 3)'(0), length, dropped, done, voiced_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            quiet_reg     <= '0;
            voiced_reg    <= 1'b0;
            inseg_reg     <= 1'b0;
            seg_reg       <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (advance) begin
                quiet_reg  <= quiet_next;
                voiced_reg <= voiced_next;
                inseg_reg  <= inseg_next;
                seg_reg    <= seg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A voiced detector always has an open segment.
    a_voiced_in_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        voiced_reg |-> inseg_reg)
        else $error("voiced without an open segment");

    // Closing a segment leaves the length counter and quiet counter cleared.
    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (done || dropped)) |=> (seg_reg == '0 && quiet_reg == '0 && !inseg_reg))
        else $error("segment close did not clear the detector");

    // A closing result is never voiced and never both done and dropped.
    a_close_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1] || m_tdata[2])) |-> (!m_tdata[0] && (m_tdata[1] != m_tdata[2])))
        else $error("inconsistent segment close result");

    // No segment length grows while no segment is open.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !inseg_reg |-> (seg_reg == '0))
        else $error("segment length held outside a segment");

endmodule

[hdl/energy_vad_segmenter.sv]
// Energy voice activity detector with hangover and segment qualification.
// Top level; depends on evs_pkg, evs_cfg, evs_accum, evs_thresh and evs_decide.
//
// Usage:
//   The slave channel takes one signed 16-bit PCM sample per request in
//   s_tdata, with s_tlast high on the last sample of an analysis frame.
//   A frame also closes by itself at MAX_FRAME_SAMPLES samples.
//   For every closed frame the master channel delivers one result; samples
//   inside a frame produce none.
//   The result of a frame passes the square, accumulate, threshold product
//   and decision registers after its last sample is accepted. Throughput:
//   one sample per cycle while no frame result is held up, set by the single
//   multiply-accumulate per sample and one multiply and compare per frame,
//   each with a register behind it.
//   When the receiver stalls, the result stays in the output register and
//   the pipeline keeps taking samples until a frame result has nowhere to go;
//   s_tready then drops until space frees up.
//   Reset (aresetn low, synchronous) empties the pipeline, clears the frame and
//   segment state and loads the register defaults. The user must write registers
//   over APB only while the block is idle (not enforced); pready is always high.
module energy_vad_segmenter
    import evs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] pcm_sample
    input  logic                s_tlast,   // frame_end
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] voice_active, [1] segment_done, [2] segment_dropped,
    // [34:3] segment_length, [39:35] zero
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    cfg_t   cfg;
    frame_t frame;
    logic   frame_valid;
    logic   frame_ready;
    judge_t judge;
    logic   judge_valid;
    logic   judge_ready;

    evs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    evs_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   ($signed(s_tdata[PCM_W-1:0])),
        .in_last     (s_tlast),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    evs_thresh u_thresh (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frame_valid),
        .in_ready  (frame_ready),
        .in_frame  (frame),
        .threshold (cfg.threshold),
        .out_valid (judge_valid),
        .out_ready (judge_ready),
        .out_judge (judge)
    );

    evs_decide u_decide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (judge_valid),
        .in_ready (judge_ready),
        .in_judge (judge),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[tb/sv/tb_energy_vad_segmenter.sv]
// Self-checking testbench for energy_vad_segmenter: drives PCM frames and APB writes,
// predicts every frame verdict and compares it with the result stream.
// Depends on evs_pkg and the energy_vad_segmenter RTL only.
`timescale 1ns / 1ps

module tb_energy_vad_segmenter
    import evs_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_HANGOVER  = {REG_HANGOVER, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_MIN_SEG   = {REG_MIN_SEG, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = 4'hC;

    typedef enum {FRAME_QUIET, FRAME_LOUD, FRAME_NOISE} frame_kind_t;

    // Bit 0 of m_tdata is voice, so the packed order runs from the top field down.
    typedef struct packed {
        logic [SEG_W-1:0] length;
        logic             dropped;
        logic             done;
        logic             voice;
    } verdict_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [15:0] pcm_sample
    logic                s_tlast;   // frame_end
    logic                m_tvalid;
    logic                m_tready;
    // [0] voice_active, [1] segment_done, [2] segment_dropped,
    // [34:3] segment_length, [39:35] zero
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    energy_vad_segmenter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Mirror of the detector: configuration plus frame and segment state.
    cfg_t               vad_cfg;
    logic [SUM_W-1:0]   p_energy;
    logic [CNT_W-1:0]   p_frame_len;
    logic [QUIET_W-1:0] p_quiet;
    logic               p_voiced;
    logic               p_seg_open;
    logic [SEG_W-1:0]   p_seg_len;

    verdict_t expected_verdicts[$];

    int  failures     = 0;
    int  mismatches   = 0;
    int  sent_samples = 0;
    int  verdicts_ok  = 0;
    int  segs_done    = 0;
    int  segs_dropped = 0;
    int  cfg_writes   = 0;
    int  quiet_cycles = 0;
    bit  gap_enable   = 1'b1;
    bit  stall_enable = 1'b1;
    bit  hold_off_req = 1'b0;

    task automatic vad_predict(input logic [PCM_W-1:0] pcm, input logic last);
        logic [PCM_W-1:0]  mag;
        logic [SUM_W:0]    sum_next;
        logic [PROD_W-1:0] bar;
        logic [SEG_W:0]    seg_next;
        logic [CNT_W-1:0]  n;
        logic              close;
        logic              loud;
        verdict_t          v;
        mag = pcm[PCM_W-1] ? (~pcm + 1'b1) : pcm;
        sum_next = {1'b0, p_energy} + (SUM_W + 1)'(mag) * (SUM_W + 1)'(mag);
        p_energy = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
        if (p_frame_len < MAX_FRAME_SAMPLES)
            p_frame_len = p_frame_len + 1'b1;
        close = last || (p_frame_len >= MAX_FRAME_SAMPLES);
        if (!close)
            return;

        n = p_frame_len;
        bar = PROD_W'(vad_cfg.threshold) * PROD_W'(n);
        loud = p_energy > bar;
        p_energy = '0;
        p_frame_len = '0;

        if (loud) begin
            p_voiced = 1'b1;
            p_quiet = '0;
        end else begin
            if (p_quiet != QUIET_MAX)
                p_quiet = p_quiet + 1'b1;
            if (p_quiet > vad_cfg.hangover)
                p_voiced = 1'b0;
        end

        v = '0;
        if (p_voiced) begin
            seg_next = {1'b0, p_seg_len} + (SEG_W + 1)'(n);
            p_seg_len = seg_next[SEG_W] ? SEG_MAX : seg_next[SEG_W-1:0];
            p_seg_open = 1'b1;
            v.length = p_seg_len;
        end else if (p_seg_open) begin
            // Voicing just ended: qualify the segment and clear the detector.
            v.length = p_seg_len;
            if (p_seg_len >= vad_cfg.min_segment)
                v.done = 1'b1;
            else
                v.dropped = 1'b1;
            p_seg_len = '0;
            p_seg_open = 1'b0;
            p_quiet = '0;
            p_voiced = 1'b0;
        end
        v.voice = p_voiced;
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    // Offers one sample and returns at the edge where it was accepted.
    task automatic send_sample(input logic [PCM_W-1:0] pcm, input logic last);
        if (gap_enable && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pcm;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        vad_predict(pcm, last);
        sent_samples++;
    endtask

    // Sends one closed frame; a zero length picks a random one, mostly short.
    task automatic send_frame(input int len, input frame_kind_t kind);
        int unsigned knee;
        int unsigned mag;
        longint unsigned trial;
        logic [PCM_W-1:0] pcm;
        if (len == 0)
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 48);
        // Largest magnitude whose square does not exceed the threshold.
        knee = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = knee | (32'd1 << b);
            if (trial * trial <= vad_cfg.threshold)
                knee = 32'(trial);
        end
        for (int i = 0; i < len; i++) begin
            case (kind)
                FRAME_NOISE: pcm = PCM_W'($urandom);
                FRAME_LOUD: begin
                    mag = (knee >= 32767) ? 32768 : $urandom_range(knee + 1, 32768);
                    pcm = $urandom_range(0, 1) ? PCM_W'(0 - mag) : PCM_W'(mag);
                end
                default: begin
                    mag = $urandom_range(0, (knee > 32767) ? 32767 : knee);
                    pcm = $urandom_range(0, 1) ? PCM_W'(0 - mag) : PCM_W'(mag);
                end
            endcase
            send_sample(pcm, i == len - 1);
        end
    endtask

    // Talk spurts of loud frames separated by pauses around the hangover length.
    task automatic run_speech(input int budget);
        int start;
        int spurt;
        int pause;
        start = sent_samples;
        while (sent_samples - start < budget) begin
            spurt = $urandom_range(1, 5);
            pause = (vad_cfg.hangover > 6) ? $urandom_range(0, 8)
                                           : $urandom_range(0, vad_cfg.hangover + 2);
            repeat (spurt)
                send_frame(0, ($urandom_range(0, 5) == 0) ? FRAME_NOISE : FRAME_LOUD);
            repeat (pause)
                send_frame(0, ($urandom_range(0, 5) == 0) ? FRAME_NOISE : FRAME_QUIET);
        end
    endtask

    // Stops the sender and waits until every verdict is in and the pipeline is empty.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The idle state between transfers keeps back-to-back writes apart.
        @(posedge aclk);
        case (addr)
            ADDR_THRESHOLD: vad_cfg.threshold   = value[THR_W-1:0];
            ADDR_HANGOVER:  vad_cfg.hangover    = value[HANG_W-1:0];
            ADDR_MIN_SEG:   vad_cfg.min_segment = value[SEG_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic test_reset_defaults();
        // Two-sample loud frame, then eleven quiet frames outlast the default hangover.
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        repeat (11) send_sample(16'h0000, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_threshold_edges();
        cfg_write(ADDR_HANGOVER, 32'hFFFF_FF00);
        cfg_write(ADDR_MIN_SEG, 32'h0000_0000);
        cfg_write(ADDR_THRESHOLD, 32'h800F_4240);
        // Mean square equal to the threshold is still quiet; one step above is loud.
        send_sample(PCM_W'(1000), 1'b0);
        send_sample(PCM_W'(-1000), 1'b1);
        send_sample(PCM_W'(1001), 1'b1);
        send_sample(16'h0000, 1'b1);
        wait_for_drain();
        cfg_write(ADDR_THRESHOLD, 32'h0000_0000);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b1);
        wait_for_drain();
        cfg_write(ADDR_MIN_SEG, 32'hFFFF_FFFF);
        cfg_write(ADDR_THRESHOLD, 32'h4000_0000);
        send_sample(16'h8000, 1'b1);
        wait_for_drain();
        cfg_write(ADDR_THRESHOLD, 32'h3FFF_FFFF);
        cfg_write(ADDR_UNMAPPED, 32'h0000_0000);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b1);
        wait_for_drain();
        cfg_write(ADDR_THRESHOLD, 32'hFFFF_FFFF);
        send_sample(16'h8000, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_counter_limits();
        cfg_write(ADDR_THRESHOLD, APB_W'(THR_RESET));
        cfg_write(ADDR_HANGOVER, 32'h0000_00FF);
        cfg_write(ADDR_MIN_SEG, 32'd256);
        send_sample(16'h7FFF, 1'b1);
        // The longest hangover, then enough quiet frames to end the voicing and two more.
        repeat (256 + 2) send_sample(16'h0000, 1'b1);
        wait_for_drain();
        cfg_write(ADDR_HANGOVER, 32'h0000_0001);
        send_frame(3, FRAME_LOUD);
        repeat (2) send_frame(1, FRAME_QUIET);
        wait_for_drain();
    endtask

    task automatic test_random_speech();
        logic [APB_W-1:0] thr_word;
        logic [APB_W-1:0] hang_word;
        logic [APB_W-1:0] min_word;
        for (int phase = 0; phase < 6; phase++) begin
            wait_for_drain();
            case ($urandom_range(0, 4))
                0: thr_word = 0;
                1: thr_word = 32'h4000_0000;
                2: thr_word = $urandom_range(0, 32'h4000_0000);
                3: thr_word = $urandom_range(1, 5000);
                default: thr_word = APB_W'(THR_RESET);
            endcase
            thr_word[31] = 1'($urandom_range(0, 1));
            hang_word = $urandom;
            case ($urandom_range(0, 2))
                0: hang_word[7:0] = 8'd0;
                1: hang_word[7:0] = 8'($urandom_range(1, 6));
                default: hang_word[7:0] = 8'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 3))
                0: min_word = 0;
                1: min_word = '1;
                default: min_word = $urandom_range(1, 120);
            endcase
            cfg_write(ADDR_THRESHOLD, thr_word);
            cfg_write(ADDR_HANGOVER, hang_word);
            cfg_write(ADDR_MIN_SEG, min_word);
            gap_enable   = $urandom_range(0, 3) != 0;
            stall_enable = $urandom_range(0, 3) != 0;
            run_speech(55);
        end
        wait_for_drain();
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    task automatic test_backpressure();
        cfg_write(ADDR_THRESHOLD, APB_W'(THR_RESET));
        cfg_write(ADDR_HANGOVER, 32'd2);
        cfg_write(ADDR_MIN_SEG, 32'd10);
        gap_enable = 1'b0;
        hold_off_req = 1'b1;
        // Every sample closes a frame, so the output side fills up during the hold-off.
        repeat (120)
            send_frame(1, ($urandom_range(0, 2) == 0) ? FRAME_QUIET : FRAME_LOUD);
        gap_enable = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        run_speech(30);
        // The sender holds back here until the result stream has fully caught up.
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        run_speech(30);
        wait_for_drain();
    endtask

    task automatic test_steady_stream();
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        cfg_write(ADDR_THRESHOLD, $urandom_range(1, 2_000_000));
        cfg_write(ADDR_HANGOVER, $urandom_range(0, 4));
        cfg_write(ADDR_MIN_SEG, $urandom_range(0, 60));
        run_speech(80);
        wait_for_drain();
    endtask

    // Result side: ready stretches, random stall bursts and one long hold-off.
    initial begin : result_sink
        int  span;
        logic ready_next;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                span = HOLD_OFF_CYCLES;
                ready_next = 1'b0;
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 13);
                ready_next = 1'b0;
            end else begin
                span = $urandom_range(1, 24);
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
            repeat (span - 1) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(verdict_t)-1:0];
            if (expected_verdicts.size() == 0) begin
                failures++;
                $display("%0t: result with no frame pending: voice=%0b done=%0b %s%0b len=%0d",
                         $time, got.voice, got.done, "dropped=", got.dropped, got.length);
            end else begin
                want = expected_verdicts.pop_front();
                if (got.voice !== want.voice || got.done !== want.done ||
                    got.dropped !== want.dropped || got.length !== want.length) begin
                    failures++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: verdict mismatch: expected voice=%0b done=%0b %s%0b len=%0d",
                                 $time, want.voice, want.done, "dropped=", want.dropped,
                                 want.length);
                        $display("%0t:                   got voice=%0b done=%0b %s%0b len=%0d",
                                 $time, got.voice, got.done, "dropped=", got.dropped,
                                 got.length);
                    end
                end else begin
                    verdicts_ok++;
                end
                segs_done    += want.done;
                segs_dropped += want.dropped;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d frame verdicts outstanding",
                     $time, quiet_cycles, expected_verdicts.size());
            $display("energy_vad_segmenter regression: fail");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        vad_cfg     = '{threshold: THR_RESET, hangover: HANG_RESET, min_segment: MIN_RESET};
        p_energy    = '0;
        p_frame_len = '0;
        p_quiet     = '0;
        p_voiced    = 1'b0;
        p_seg_open  = 1'b0;
        p_seg_len   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_threshold_edges();
        test_counter_limits();
        test_random_speech();
        test_backpressure();
        test_sender_pause();
        test_steady_stream();

        $display("Sent %0d samples over %0d register writes; %0d frame verdicts matched.",
                 sent_samples, cfg_writes, verdicts_ok);
        $display("Segments closed: %0d done, %0d dropped; %0d mismatches.",
                 segs_done, segs_dropped, mismatches);
        if (failures == 0 && expected_verdicts.size() == 0)
            $display("energy_vad_segmenter regression: pass");
        else
            $display("energy_vad_segmenter regression: fail");
        $finish;
    end

endmodule
